// ----- rtl/core/hpt_pkg.sv -----
// ----------------------------------------------------------------------------
// hpt_pkg - shared types for the homogeneous point transform
// Request classes, queue entry layout, sequencer states and the 32-bit clamp.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // four exact 64-bit products summed
  localparam int ACC_W   = 66;
  localparam int Q_DEPTH = 2;

  // mode codes on the request port
  localparam logic [2:0] MODE_LOAD_FWD = 3'd0;
  localparam logic [2:0] MODE_LOAD_INV = 3'd1;
  localparam logic [2:0] MODE_POINT    = 3'd2;
  localparam logic [2:0] MODE_VECTOR   = 3'd3;
  localparam logic [2:0] MODE_NORMAL   = 3'd4;
  localparam logic [2:0] MODE_BOX      = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD_FWD,
    OP_LOAD_INV,
    OP_POINT,
    OP_VECTOR,
    OP_NORMAL,
    OP_BOX,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  idx;
    logic [31:0] value;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROW,
    ST_FIN,
    ST_DIV,
    ST_MERGE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  localparam logic signed [ACC_W-1:0] MAX32 = {{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W-1:0] MIN32 = {{(ACC_W-32){1'b1}}, 32'h8000_0000};

  // clamp a wide signed value into the 32-bit range
  function automatic clamp_t sat_clamp(input logic signed [ACC_W-1:0] v);
    clamp_t r;
    if (v > MAX32) begin
      r.val = 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end else if (v < MIN32) begin
      r.val = 32'h8000_0000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hpt_front.sv -----
// ----------------------------------------------------------------------------
// hpt_front - request intake
// Accepts requests, classifies the mode and packs them for the queue.
// ----------------------------------------------------------------------------
module hpt_front (
  input  logic                start_i,
  input  logic [2:0]          mode_i,
  input  logic [3:0]          entry_index_i,
  input  logic [31:0]         entry_value_i,
  input  logic [31:0]         x_in_i,
  input  logic [31:0]         y_in_i,
  input  logic [31:0]         z_in_i,
  input  logic [31:0]         x_hi_in_i,
  input  logic [31:0]         y_hi_in_i,
  input  logic [31:0]         z_hi_in_i,
  input  logic                full_i,
  output logic                busy_o,
  output logic                push_o,
  output hpt_pkg::item_t      item_o
);
  import hpt_pkg::*;

  op_e op;

  // classify the mode
  always_comb begin
    unique case (mode_i)
      MODE_LOAD_FWD: op = OP_LOAD_FWD;
      MODE_LOAD_INV: op = OP_LOAD_INV;
      MODE_POINT:    op = OP_POINT;
      MODE_VECTOR:   op = OP_VECTOR;
      MODE_NORMAL:   op = OP_NORMAL;
      MODE_BOX:      op = OP_BOX;
      default:       op = OP_NOP;
    endcase
  end

  // pack the request
  always_comb begin
    item_o.op    = op;
    item_o.idx   = entry_index_i;
    item_o.value = entry_value_i;
    item_o.lo    = {z_in_i, y_in_i, x_in_i};
    item_o.hi    = {z_hi_in_i, y_hi_in_i, x_hi_in_i};
  end

  // hold off requests while the queue is full
  assign busy_o = full_i;
  assign push_o = start_i & ~full_i;

endmodule

// ----- rtl/core/hpt_queue.sv -----
// ----------------------------------------------------------------------------
// hpt_queue - request queue
// Short FIFO between intake and execution.
// ----------------------------------------------------------------------------
module hpt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hpt_pkg::item_t item_i,
  input  logic           pop_i,
  output hpt_pkg::item_t item_o,
  output logic           empty_o,
  output logic           full_o
);
  import hpt_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  item_t         mem_q [Q_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PW+1)'(Q_DEPTH));
  assign item_o  = mem_q[rd_q];

  // advance pointers and fill count
  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // store the request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/core/hpt_div.sv -----
// ----------------------------------------------------------------------------
// hpt_div - fixed-point divider
// Restoring divide of (num << FRAC_BITS) by den, one quotient bit per cycle,
// truncated toward zero and clamped to 32 bits.
// ----------------------------------------------------------------------------
module hpt_div #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [hpt_pkg::ACC_W-FRAC_BITS-1:0] num_i,
  input  logic signed [hpt_pkg::ACC_W-FRAC_BITS-1:0] den_i,
  output logic                                   done_o,
  output hpt_pkg::clamp_t                        res_o
);
  import hpt_pkg::*;

  localparam int CW    = ACC_W - FRAC_BITS;
  localparam int NW    = ACC_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    dq_q;
  logic [CW-1:0]    den_q, rem_q;
  logic             neg_q, run_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CW-1:0]    num_mag, den_mag;
  logic [CW:0]      trial, diff;
  logic             take;

  assign num_mag = num_i[CW-1] ? CW'(-num_i) : CW'(num_i);
  assign den_mag = den_i[CW-1] ? CW'(-den_i) : CW'(den_i);
  assign trial   = {rem_q, dq_q[NW-1]};
  assign diff    = trial - {1'b0, den_q};
  assign take    = (trial >= {1'b0, den_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      den_q <= den_mag;
      rem_q <= '0;
      neg_q <= num_i[CW-1] ^ den_i[CW-1];
    end else if (run_q) begin
      rem_q <= take ? diff[CW-1:0] : trial[CW-1:0];
      dq_q  <= {dq_q[NW-2:0], take};
    end
  end

  // clamp the signed quotient
  always_comb begin
    if (!neg_q) begin
      res_o.sat = |dq_q[NW-1:31];
      res_o.val = res_o.sat ? 32'h7FFF_FFFF : dq_q[31:0];
    end else begin
      res_o.sat = (|dq_q[NW-1:32]) || (dq_q[31] && (|dq_q[30:0]));
      res_o.val = res_o.sat ? 32'h8000_0000 : 32'(-dq_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

// ----- rtl/core/hpt_back.sv -----
// ----------------------------------------------------------------------------
// hpt_back - transform engine
// Holds both matrices and runs each transform request through a shared multiplier,
// accumulator and divider under a sequencer.
// ----------------------------------------------------------------------------
module hpt_back #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hpt_pkg::item_t item_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           done_o,
  output logic [31:0]    out_x_o,
  output logic [31:0]    out_y_o,
  output logic [31:0]    out_z_o,
  output logic [31:0]    out_x_hi_o,
  output logic [31:0]    out_y_hi_o,
  output logic [31:0]    out_z_hi_o,
  output logic           w_zero_o,
  output logic           saturated_o
);
  import hpt_pkg::*;

  localparam int CW = ACC_W - FRAC_BITS;
  localparam logic [31:0]   ONE   = 32'(1) << FRAC_BITS;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  state_e state_q, state_d;
  op_e    op_q;
  logic [31:0] fwd_q [16];
  logic [31:0] inv_q [16];
  logic [31:0] lo_q [3];
  logic [31:0] hi_q [3];
  logic [31:0] t_q [3];
  logic [31:0] rlo_q [3];
  logic [31:0] rhi_q [3];
  logic signed [CW-1:0]    c_q [4];
  logic signed [ACC_W-1:0] acc_q;
  logic signed [63:0]      p_q;
  logic [2:0] k_q;
  logic [1:0] i_q, j_q, d_q;
  logic       wz_q, sat_q, done_q;

  logic        is_proj, w_zero, w_one, div_start, div_done, xform;
  logic [1:0]  last, div_sel;
  logic [3:0]  mat_idx;
  logic [31:0] a_sel, b_sel;
  clamp_t      div_res;
  clamp_t      cl [3];

  assign is_proj = (op_q == OP_POINT) || (op_q == OP_BOX);
  assign last    = is_proj ? 2'd3 : 2'd2;
  assign w_zero  = (c_q[3] == '0);
  assign w_one   = (c_q[3] == ONE_C);
  assign xform   = (item_i.op == OP_POINT) || (item_i.op == OP_VECTOR) ||
                   (item_i.op == OP_NORMAL) || (item_i.op == OP_BOX);

  // select matrix entry and vector element
  always_comb begin
    mat_idx = (op_q == OP_NORMAL) ? {j_q, i_q} : {i_q, j_q};
    a_sel   = (op_q == OP_NORMAL) ? inv_q[mat_idx] : fwd_q[mat_idx];
    b_sel   = (j_q == 2'd3) ? ONE : (k_q[j_q] ? hi_q[j_q] : lo_q[j_q]);
  end

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      cl[m] = sat_clamp(ACC_W'(c_q[m]));
    end
  end

  assign div_sel = (state_q == ST_DIV) ? d_q + 2'd1 : d_q;

  hpt_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (c_q[div_sel]),
    .den_i  (c_q[3]),
    .done_o (div_done),
    .res_o  (div_res)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and strobes
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (xform) state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = (j_q == last) ? ST_ROW : ST_MUL;
      ST_ROW: state_d = (i_q == last) ? ST_FIN : ST_MUL;
      ST_FIN: begin
        if (!is_proj || w_zero || w_one) begin
          state_d = ST_MERGE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (d_q == 2'd2) begin
            state_d = ST_MERGE;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_MERGE: state_d = ((op_q == OP_BOX) && (k_q != 3'd7)) ? ST_MUL : ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // matrices and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 16; e++) begin
        fwd_q[e] <= (e % 5 == 0) ? ONE : '0;
        inv_q[e] <= (e % 5 == 0) ? ONE : '0;
      end
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (pop_o) begin
        if (item_i.op == OP_LOAD_FWD) fwd_q[item_i.idx] <= item_i.value;
        if (item_i.op == OP_LOAD_INV) inv_q[item_i.idx] <= item_i.value;
        if (!xform) done_q <= 1'b1;
      end
      if (state_q == ST_OUT) done_q <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          op_q  <= item_i.op;
          k_q   <= '0;
          i_q   <= '0;
          j_q   <= '0;
          d_q   <= '0;
          acc_q <= '0;
          wz_q  <= 1'b0;
          sat_q <= 1'b0;
          for (int m = 0; m < 3; m++) begin
            lo_q[m]  <= item_i.lo[m];
            hi_q[m]  <= item_i.hi[m];
            rlo_q[m] <= '0;
            rhi_q[m] <= '0;
          end
        end
      end
      ST_MUL: p_q <= $signed(a_sel) * $signed(b_sel);
      ST_ACC: begin
        acc_q <= acc_q + ACC_W'(p_q);
        j_q   <= j_q + 2'd1;
      end
      ST_ROW: begin
        c_q[i_q] <= CW'(acc_q >>> FRAC_BITS);
        acc_q    <= '0;
        j_q      <= '0;
        i_q      <= i_q + 2'd1;
      end
      ST_FIN: begin
        // no divide: clamp the undivided coordinates
        if (!is_proj || w_zero || w_one) begin
          for (int m = 0; m < 3; m++) t_q[m] <= cl[m].val;
          if (cl[0].sat || cl[1].sat || cl[2].sat) sat_q <= 1'b1;
          if (is_proj && w_zero) wz_q <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          t_q[d_q] <= div_res.val;
          if (div_res.sat) sat_q <= 1'b1;
          d_q <= d_q + 2'd1;
        end
      end
      ST_MERGE: begin
        // fold the corner into the running box, or take the result as is
        for (int m = 0; m < 3; m++) begin
          if (op_q == OP_BOX) begin
            if (k_q == 3'd0 || $signed(t_q[m]) < $signed(rlo_q[m])) rlo_q[m] <= t_q[m];
            if (k_q == 3'd0 || $signed(t_q[m]) > $signed(rhi_q[m])) rhi_q[m] <= t_q[m];
          end else begin
            rlo_q[m] <= t_q[m];
          end
        end
        k_q <= k_q + 3'd1;
        i_q <= '0;
        j_q <= '0;
        d_q <= '0;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign done_o      = done_q;
  assign out_x_o     = rlo_q[0];
  assign out_y_o     = rlo_q[1];
  assign out_z_o     = rlo_q[2];
  assign out_x_hi_o  = rhi_q[0];
  assign out_y_hi_o  = rhi_q[1];
  assign out_z_hi_o  = rhi_q[2];
  assign w_zero_o    = wz_q;
  assign saturated_o = sat_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("queue popped outside idle");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |=> done_q)
    else $error("finished transform gave no result");

  a_wz_proj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && wz_q) |-> (op_q == OP_POINT || op_q == OP_BOX))
    else $error("w_zero flagged on a non-projective request");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (is_proj && !w_zero && !w_one))
    else $error("divider started without a valid divisor");
`endif

endmodule

// ----- rtl/core/homogeneous_point_transform.sv -----
// ----------------------------------------------------------------------------
// homogeneous_point_transform - 4x4 Q16.16 transform unit
// Transforms points, vectors, normals and boxes by stored matrices.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request on the input ports with start_i high; it is taken on a
//   clock edge where busy_o is low. Requests pass a two-entry queue to the
//   engine, so up to two may be taken while an earlier one is still running.
//   Each request gives one result, shown for a single cycle with done_o high;
//   the receiver cannot stall, so results must be taken when shown.
//   Loads update the forward or inverse matrix entry in queue order, so a
//   transform always sees every load taken before it, and return zeros.
// Speed is set by the one shared 32x32 multiplier and the one-bit-per-cycle
// divider. A point needs the divider only when w is neither zero nor one;
// a box is run as its eight corner points.
// Reset sets both matrices to identity and empties the queue.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] entry_value_i,
  input  logic [31:0] x_in_i,
  input  logic [31:0] y_in_i,
  input  logic [31:0] z_in_i,
  input  logic [31:0] x_hi_in_i,
  input  logic [31:0] y_hi_in_i,
  input  logic [31:0] z_hi_in_i,
  output logic        done_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [31:0] out_x_hi_o,
  output logic [31:0] out_y_hi_o,
  output logic [31:0] out_z_hi_o,
  output logic        w_zero_o,
  output logic        saturated_o
);
  import hpt_pkg::*;

  item_t push_item, head_item;
  logic  push, pop, full, empty;

  hpt_front u_front (
    .start_i      (start_i),
    .mode_i       (mode_i),
    .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i),
    .x_in_i       (x_in_i),
    .y_in_i       (y_in_i),
    .z_in_i       (z_in_i),
    .x_hi_in_i    (x_hi_in_i),
    .y_hi_in_i    (y_hi_in_i),
    .z_hi_in_i    (z_hi_in_i),
    .full_i       (full),
    .busy_o       (busy_o),
    .push_o       (push),
    .item_o       (push_item)
  );

  hpt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .empty_o(empty),
    .full_o (full)
  );

  hpt_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (head_item),
    .empty_i    (empty),
    .pop_o      (pop),
    .done_o     (done_o),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o),
    .out_x_hi_o (out_x_hi_o),
    .out_y_hi_o (out_y_hi_o),
    .out_z_hi_o (out_z_hi_o),
    .w_zero_o   (w_zero_o),
    .saturated_o(saturated_o)
  );

endmodule
